// ===== hdl/biphasic_stim_pulse_sequencer_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BIPHASIC_STIM_PULSE_SEQUENCER_CORE_DEFINES_SVH
`define BIPHASIC_STIM_PULSE_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define BSPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define BSPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bsps_pkg.sv =====
package bsps_pkg;

  // Bridge phases, also the bridge_mode code on the result
  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_FWD   = 2'd1,
    PH_REV   = 2'd2,
    PH_SHORT = 2'd3
  } phase_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LEN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LEN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY    = 3'd4;

  // Register defaults
  localparam logic [15:0] DRIVE_LEN_RST      = 16'd60;
  localparam logic [15:0] CYCLE_LEN_RST      = 16'd6692;
  localparam logic [9:0]  LOW_THRESHOLD_RST  = 10'd586;
  localparam logic [13:0] CHECK_INTERVAL_RST = 14'd10000;
  localparam logic [15:0] START_DELAY_RST    = 16'd5000;

  // LED settings
  localparam logic [15:0] LED_PERIOD_NORMAL = 16'd180;
  localparam logic [15:0] LED_DUTY_NORMAL   = 16'd1;
  localparam logic [15:0] LED_PERIOD_LOW    = 16'd24000;
  localparam logic [15:0] LED_DUTY_LOW      = 16'd2;

  localparam int TICKS_W = 17;

  typedef struct packed {
    logic       kind;
    logic [9:0] adc_value;
  } item_t;

  typedef struct packed {
    logic [1:0]  bridge_mode;
    logic        measure_pin;
    logic        adc_start;
    logic [15:0] led_period;
    logic [15:0] led_duty;
    logic        low_battery;
  } result_t;

  typedef struct packed {
    logic [15:0] drive_len;
    logic [15:0] cycle_len;
    logic [9:0]  low_voltage_threshold;
    logic [13:0] check_interval;
    logic [15:0] start_delay;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;
  } cfg_write_t;

  // Jitter offsets, repeated cyclically over deeper tables
  localparam logic [10:0] JITTER_BASE [32] = '{
    11'd1137, 11'd938,  11'd23,   11'd674,  11'd324,  11'd1588, 11'd622,  11'd1057,
    11'd331,  11'd1203, 11'd525,  11'd1308, 11'd1378, 11'd1496, 11'd901,  11'd167,
    11'd457,  11'd1826, 11'd304,  11'd1651, 11'd1076, 11'd1992, 11'd156,  11'd885,
    11'd213,  11'd1923, 11'd9,    11'd1549, 11'd1634, 11'd1737, 11'd168,  11'd799
  };

  function automatic logic [10:0] jitter_offset(input logic [7:0] idx);
    return JITTER_BASE[idx[4:0]];
  endfunction

  // A zero length counts as one tick
  function automatic logic [TICKS_W-1:0] at_least_one(input logic [TICKS_W-1:0] v);
    return (v == '0) ? TICKS_W'(1) : v;
  endfunction

endpackage

// ===== hdl/biphasic_stim_pulse_sequencer_core.sv =====
// Biphasic stimulation pulse sequencer.
// Item channel (item_valid/item_stall/item): each beat is one timer tick
// (kind 0) or a finished supply conversion (kind 1, adc_value).
// Result channel (result_valid/result_stall/result): exactly one beat per
// item, giving bridge mode, measure pin, conversion request and LED setting.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
// always high; write only while no item is in flight.
// Path: the item register loads at the accepting edge and the sequencer
// logic loads the result register from it once the result register is free,
// so result_stall can hold a beat between the two registers.
// Throughput is one item per cycle while result_stall is low, set by the
// per-item state update of the sequencer (phase timer, jitter index, pulse counter).
// When result_stall is high the result register holds; the item register
// keeps taking one more beat, then item_stall rises.
// Synchronous reset loads register defaults, opens the bridge and starts
// the start-delay count; both channels come out of reset empty.
module biphasic_stim_pulse_sequencer_core
  import bsps_pkg::*;
#(
  parameter int JITTER_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  item_t              item_q;
  logic               item_q_valid;
  logic               out_free, advance, accept;
  cfg_write_t         wr;
  cfg_t               cfg;
  logic [TICKS_W-1:0] gap_base;
  result_t            res;

  assign cfg_ready = 1'b1;
  assign wr.valid  = cfg_valid && cfg_ready;
  assign wr.index  = cfg_index;
  assign wr.data   = cfg_data;

  assign out_free   = !result_valid || !result_stall;
  assign advance    = item_q_valid && out_free;
  assign item_stall = item_q_valid && !out_free;
  assign accept     = item_valid && !item_stall;

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (accept) begin
      item_q_valid <= 1'b1;
    end else if (advance) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  bsps_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .cfg      (cfg),
    .gap_base (gap_base)
  );

  bsps_engine #(
    .JITTER_DEPTH (JITTER_DEPTH)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (item_q),
    .cfg      (cfg),
    .gap_base (gap_base),
    .wr       (wr),
    .res      (res)
  );

  // Load the result register; drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

endmodule

// ===== hdl/bsps_cfg_regs.sv =====
module bsps_cfg_regs
  import bsps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_write_t          wr,
  output cfg_t                cfg,
  output logic [TICKS_W-1:0]  gap_base
);

  logic [TICKS_W-1:0] twice_width;

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_len             <= DRIVE_LEN_RST;
      cfg.cycle_len             <= CYCLE_LEN_RST;
      cfg.low_voltage_threshold <= LOW_THRESHOLD_RST;
      cfg.check_interval        <= CHECK_INTERVAL_RST;
      cfg.start_delay           <= START_DELAY_RST;
    end else if (wr.valid) begin
      unique case (wr.index)
        REG_DRIVE_LEN:      cfg.drive_len             <= wr.data;
        REG_CYCLE_LEN:      cfg.cycle_len             <= wr.data;
        REG_LOW_THRESHOLD:  cfg.low_voltage_threshold <= wr.data[9:0];
        REG_CHECK_INTERVAL: cfg.check_interval        <= wr.data[13:0];
        REG_START_DELAY:    cfg.start_delay           <= wr.data;
        default: ;
      endcase
    end
  end

  // Gap before jitter: period minus both drive phases, floored at zero
  assign twice_width = {cfg.drive_len, 1'b0};
  assign gap_base = ({1'b0, cfg.cycle_len} > twice_width)
                    ? ({1'b0, cfg.cycle_len} - twice_width) : '0;

endmodule

// ===== hdl/bsps_engine.sv =====
module bsps_engine
  import bsps_pkg::*;
#(
  parameter int JITTER_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  item_t              item,
  input  cfg_t               cfg,
  input  logic [TICKS_W-1:0] gap_base,
  input  cfg_write_t         wr,
  output result_t            res
);

  localparam int IDX_W = $clog2(JITTER_DEPTH);

  phase_t             phase, phase_next;
  logic [TICKS_W-1:0] ticks_left, ticks_left_next;
  logic [IDX_W-1:0]   jitter_index, jitter_index_next;
  logic [13:0]        pulse_count, pulse_count_next, pulse_inc;
  logic               battery_low_flag, battery_low_flag_next;
  logic               measure_level, measure_level_next;
  logic               adc_start;
  logic [TICKS_W-1:0] width_ticks, gap_ticks;

  assign width_ticks = at_least_one({1'b0, cfg.drive_len});
  assign gap_ticks   = at_least_one(gap_base + TICKS_W'(jitter_offset(8'(jitter_index))));
  assign pulse_inc   = pulse_count + 14'd1;

  // Work out the next state for one item
  always_comb begin
    phase_next            = phase;
    ticks_left_next       = ticks_left;
    jitter_index_next     = jitter_index;
    pulse_count_next      = pulse_count;
    battery_low_flag_next = battery_low_flag;
    measure_level_next    = measure_level;
    adc_start             = 1'b0;
    if (!item.kind) begin
      if (ticks_left > TICKS_W'(1)) begin
        ticks_left_next = ticks_left - TICKS_W'(1);
      end else begin
        unique case (phase)
          PH_WAIT, PH_SHORT: begin
            phase_next      = PH_FWD;
            ticks_left_next = width_ticks;
          end
          PH_FWD: begin
            phase_next      = PH_REV;
            ticks_left_next = width_ticks;
          end
          PH_REV: begin
            phase_next        = PH_SHORT;
            ticks_left_next   = gap_ticks;
            jitter_index_next = (jitter_index == IDX_W'(JITTER_DEPTH - 1))
                                ? '0 : jitter_index + IDX_W'(1);
            if (pulse_inc >= cfg.check_interval) begin
              pulse_count_next   = '0;
              measure_level_next = 1'b1;
              adc_start          = 1'b1;
            end else begin
              pulse_count_next = pulse_inc;
            end
          end
          default: ;
        endcase
      end
    end else begin
      battery_low_flag_next = item.adc_value < cfg.low_voltage_threshold;
      measure_level_next    = 1'b0;
    end
  end

  // Hold sequencer state; a start delay write during the start wait reloads the timer when no item advances
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_WAIT;
      ticks_left       <= {1'b0, START_DELAY_RST};
      jitter_index     <= '0;
      pulse_count      <= '0;
      battery_low_flag <= 1'b0;
      measure_level    <= 1'b0;
    end else if (advance) begin
      phase            <= phase_next;
      ticks_left       <= ticks_left_next;
      jitter_index     <= jitter_index_next;
      pulse_count      <= pulse_count_next;
      battery_low_flag <= battery_low_flag_next;
      measure_level    <= measure_level_next;
    end else if (wr.valid && wr.index == REG_START_DELAY && phase == PH_WAIT) begin
      ticks_left <= at_least_one({1'b0, wr.data});
    end
  end

  // Build the result from the updated state
  always_comb begin
    res.bridge_mode = phase_next;
    res.measure_pin = measure_level_next;
    res.adc_start   = adc_start;
    res.led_period  = battery_low_flag_next ? LED_PERIOD_LOW : LED_PERIOD_NORMAL;
    res.led_duty    = battery_low_flag_next ? LED_DUTY_LOW : LED_DUTY_NORMAL;
    res.low_battery = battery_low_flag_next;
  end

endmodule

// ===== hdl/bsps_checker.sv =====
`include "biphasic_stim_pulse_sequencer_core_defines.svh"

module bsps_checker
  import bsps_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_stall,
  input item_t                item,
  input logic                 result_valid,
  input logic                 result_stall,
  input result_t              result
);

  `BSPS_ASSERT_NEXT(a_item_hold, clk, rst, item_valid && item_stall,
    item_valid && $stable(item), "stalled item beat changed")

  `BSPS_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall,
    result_valid && $stable(result), "stalled result beat changed")

  `BSPS_ASSERT_NOW(a_start_raises_pin, clk, rst, result_valid && result.adc_start,
    result.measure_pin, "conversion request without measure pin")

  `BSPS_ASSERT_NOW(a_start_in_short, clk, rst, result_valid && result.adc_start,
    result.bridge_mode == PH_SHORT, "conversion request outside shorted phase")

  `BSPS_ASSERT_NOW(a_led_setting, clk, rst, result_valid,
    (result.low_battery && result.led_period == LED_PERIOD_LOW
       && result.led_duty == LED_DUTY_LOW)
    || (!result.low_battery && result.led_period == LED_PERIOD_NORMAL
       && result.led_duty == LED_DUTY_NORMAL),
    "LED setting does not match battery flag")

endmodule

bind biphasic_stim_pulse_sequencer_core bsps_checker u_bsps_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== dv/tb_biphasic_stim_pulse_sequencer_core.sv =====
`timescale 1ns / 100ps

module tb_biphasic_stim_pulse_sequencer_core;
  import bsps_pkg::*;

  localparam int CYCLE_LIMIT      = 3000000;
  localparam int DRAIN_LIMIT      = 20000;
  localparam int RANDOM_ITEMS     = 1300;
  localparam int NUM_PHASES       = 8;
  localparam int FILL_LOW_MARK    = 64;
  localparam int REPORT_MAX       = 10;
  localparam int SEQ_JITTER_DEPTH = 32;
  localparam int LONG_HOLD_AT     = 200;
  localparam int LONG_HOLD_CYCLES = 400;

  // Gap offsets, one per pulse, in table order
  localparam logic [10:0] GAP_JITTER [32] = '{
    11'd1137, 11'd938,  11'd23,   11'd674,  11'd324,  11'd1588, 11'd622,  11'd1057,
    11'd331,  11'd1203, 11'd525,  11'd1308, 11'd1378, 11'd1496, 11'd901,  11'd167,
    11'd457,  11'd1826, 11'd304,  11'd1651, 11'd1076, 11'd1992, 11'd156,  11'd885,
    11'd213,  11'd1923, 11'd9,    11'd1549, 11'd1634, 11'd1737, 11'd168,  11'd799
  };

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  item_t                item         = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [15:0]          cfg_data     = '0;

  biphasic_stim_pulse_sequencer_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Sequencer shadow state and register copy
  cfg_t               shadow_cfg;
  phase_t             seq_phase;
  logic [TICKS_W-1:0] ticks_left;
  int                 jitter_idx;
  logic [13:0]        pulse_cnt;
  logic               low_flag;
  logic               measure_level;

  item_t       pending_items [$];
  result_t     seq_outputs_q [$];
  bit          offer_busy    = 1'b0;
  int          burst_left    = 0;
  int          gap_left      = 0;
  int          hold_left     = 0;
  bit          hold_done     = 1'b0;
  int          mode_left     = 0;
  int          stall_pct     = 0;
  int          results_total = 0;
  int          mismatches    = 0;
  int unsigned cycle_count   = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // A phase length of zero still lasts one tick
  function automatic logic [TICKS_W-1:0] min_one_tick(input logic [TICKS_W-1:0] v);
    return v | TICKS_W'(v == '0);
  endfunction

  function automatic item_t mk_item(input logic is_conv, input logic [9:0] adc);
    item_t it;
    it.kind      = is_conv;
    it.adc_value = adc;
    return it;
  endfunction

  // Advance the shadow sequencer by one beat and return the output it shows
  function automatic result_t step_sequencer(input item_t it);
    result_t            r;
    logic [TICKS_W-1:0] twice;
    logic [TICKS_W-1:0] gap_base;
    r = '0;
    if (!it.kind) begin
      if (ticks_left > 1) begin
        ticks_left = ticks_left - 1'b1;
      end else begin
        case (seq_phase)
          PH_FWD: begin
            seq_phase  = PH_REV;
            ticks_left = min_one_tick({1'b0, shadow_cfg.drive_len});
          end
          PH_REV: begin
            // gap saturates at zero when the drive phases overrun the period
            twice    = {shadow_cfg.drive_len, 1'b0};
            gap_base = ({1'b0, shadow_cfg.cycle_len} > twice) ?
                       {1'b0, shadow_cfg.cycle_len} - twice : '0;
            seq_phase  = PH_SHORT;
            ticks_left = min_one_tick(gap_base + GAP_JITTER[jitter_idx]);
            jitter_idx = (jitter_idx == SEQ_JITTER_DEPTH - 1) ? 0 : jitter_idx + 1;
            pulse_cnt  = pulse_cnt + 1'b1;
            if (pulse_cnt >= shadow_cfg.check_interval) begin
              pulse_cnt     = '0;
              measure_level = 1'b1;
              r.adc_start   = 1'b1;
            end
          end
          default: begin
            seq_phase  = PH_FWD;
            ticks_left = min_one_tick({1'b0, shadow_cfg.drive_len});
          end
        endcase
      end
    end else begin
      low_flag      = (it.adc_value < shadow_cfg.low_voltage_threshold);
      measure_level = 1'b0;
    end
    r.bridge_mode = seq_phase;
    r.measure_pin = measure_level;
    r.led_period  = low_flag ? LED_PERIOD_LOW : LED_PERIOD_NORMAL;
    r.led_duty    = low_flag ? LED_DUTY_LOW : LED_DUTY_NORMAL;
    r.low_battery = low_flag;
    return r;
  endfunction

  // Write one register and mirror it into the shadow copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DRIVE_LEN:      shadow_cfg.drive_len             = data;
      REG_CYCLE_LEN:      shadow_cfg.cycle_len             = data;
      REG_LOW_THRESHOLD:  shadow_cfg.low_voltage_threshold = data[9:0];
      REG_CHECK_INTERVAL: shadow_cfg.check_interval        = data[13:0];
      REG_START_DELAY: begin
        shadow_cfg.start_delay = data;
        if (seq_phase == PH_WAIT) ticks_left = min_one_tick({1'b0, data});
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued beat has gone through and come back
  task automatic wait_idle();
    while (pending_items.size() != 0 || offer_busy || seq_outputs_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sender: bursts of beats with random gaps, payload held while stalled
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!offer_busy) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
        offer_busy = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern changing over time, plus long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (!hold_done && results_total >= LONG_HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 3999) == 0) begin
      hold_left = $urandom_range(100, LONG_HOLD_CYCLES);
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 75;
        endcase
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Predict on each accepted item beat, check each accepted result beat
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        seq_outputs_q.push_back(step_sequencer(item));
        offer_busy = 1'b0;
      end
      if (result_valid && !result_stall) begin
        results_total++;
        if (seq_outputs_q.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: result beat with nothing pending, bridge_mode %0d", $realtime,
                     result.bridge_mode);
          mismatches++;
        end else begin
          want = seq_outputs_q.pop_front();
          if (want.bridge_mode !== result.bridge_mode ||
              want.measure_pin !== result.measure_pin ||
              want.adc_start   !== result.adc_start   ||
              want.led_period  !== result.led_period  ||
              want.led_duty    !== result.led_duty    ||
              want.low_battery !== result.low_battery) begin
            if (mismatches < REPORT_MAX)
              $display({"%0t: mismatch (exp/act) bridge_mode %0d/%0d measure_pin %0b/%0b",
                        " adc_start %0b/%0b led_period %0d/%0d led_duty %0d/%0d",
                        " low_battery %0b/%0b"}, $realtime,
                       want.bridge_mode, result.bridge_mode,
                       want.measure_pin, result.measure_pin,
                       want.adc_start, result.adc_start,
                       want.led_period, result.led_period,
                       want.led_duty, result.led_duty,
                       want.low_battery, result.low_battery);
            mismatches++;
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_biphasic_stim_pulse_sequencer_core: FAIL");
      $finish;
    end
  end

  initial begin
    int         p;
    int         items_done;
    int         drain;
    logic [9:0] adc;

    // Shadow state after reset
    shadow_cfg.drive_len             = DRIVE_LEN_RST;
    shadow_cfg.cycle_len             = CYCLE_LEN_RST;
    shadow_cfg.low_voltage_threshold = LOW_THRESHOLD_RST;
    shadow_cfg.check_interval        = CHECK_INTERVAL_RST;
    shadow_cfg.start_delay           = START_DELAY_RST;
    seq_phase     = PH_WAIT;
    ticks_left    = {1'b0, START_DELAY_RST};
    jitter_idx    = 0;
    pulse_cnt     = '0;
    low_flag      = 1'b0;
    measure_level = 1'b0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // A few ticks at the reset settings: bridge stays open
    pending_items.push_back(mk_item(1'b0, 10'h000));
    pending_items.push_back(mk_item(1'b0, 10'h3FF));
    pending_items.push_back(mk_item(1'b0, 10'h155));
    wait_idle();

    // Reload the start wait several times, zero counting as one tick
    write_reg(REG_START_DELAY, 16'hFFFF);
    write_reg(REG_START_DELAY, 16'h0000);
    write_reg(REG_START_DELAY, 16'd3);
    write_reg(REG_DRIVE_LEN, 16'd2);
    write_reg(REG_CYCLE_LEN, 16'd0);
    write_reg(REG_LOW_THRESHOLD, 16'hFFFF);
    write_reg(REG_CHECK_INTERVAL, 16'hC001);

    // Walk wait, forward, reverse, shorted; conversions do not tick the timer
    pending_items.push_back(mk_item(1'b0, 10'h2AA));
    pending_items.push_back(mk_item(1'b0, 10'h000));
    pending_items.push_back(mk_item(1'b1, 10'd512));
    pending_items.push_back(mk_item(1'b0, 10'h3FF));
    pending_items.push_back(mk_item(1'b0, 10'h000));
    pending_items.push_back(mk_item(1'b0, 10'h000));
    pending_items.push_back(mk_item(1'b1, 10'd1023));
    pending_items.push_back(mk_item(1'b0, 10'h000));
    pending_items.push_back(mk_item(1'b0, 10'h000));
    pending_items.push_back(mk_item(1'b1, 10'd0));
    pending_items.push_back(mk_item(1'b1, 10'd1022));
    pending_items.push_back(mk_item(1'b1, 10'd1023));
    pending_items.push_back(mk_item(1'b0, 10'h3FF));
    pending_items.push_back(mk_item(1'b0, 10'h3FF));
    wait_idle();

    // Zero threshold never reads low; start delay outside the wait is ignored
    write_reg(REG_LOW_THRESHOLD, 16'hFC00);
    write_reg(REG_START_DELAY, 16'd7);
    pending_items.push_back(mk_item(1'b1, 10'd0));
    pending_items.push_back(mk_item(1'b1, 10'h3FF));
    pending_items.push_back(mk_item(1'b0, 10'h000));
    pending_items.push_back(mk_item(1'b0, 10'h000));

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(REG_DRIVE_LEN, 16'($urandom_range(1, 4)));
          write_reg(REG_CYCLE_LEN, 16'($urandom_range(0, 20)));
          write_reg(REG_LOW_THRESHOLD, 16'($urandom));
          write_reg(REG_CHECK_INTERVAL,
                    16'($urandom_range(1, 3)) | (16'($urandom_range(0, 3)) << 14));
          write_reg(REG_START_DELAY, 16'($urandom));
        end
        1: begin
          write_reg(REG_DRIVE_LEN, 16'd0);
          write_reg(REG_CYCLE_LEN, 16'd5);
          write_reg(REG_CHECK_INTERVAL, 16'd0);
          write_reg(REG_LOW_THRESHOLD, 16'($urandom_range(400, 700)));
        end
        2: begin
          write_reg(REG_DRIVE_LEN, 16'($urandom_range(1, 8)));
          write_reg(REG_CYCLE_LEN, 16'($urandom_range(0, 40)));
          write_reg(REG_CHECK_INTERVAL, 16'hFFFF);
          write_reg(REG_LOW_THRESHOLD, 16'd0);
        end
        3: begin
          // lower the interval below the running pulse count
          write_reg(REG_DRIVE_LEN, 16'd3);
          write_reg(REG_CYCLE_LEN, 16'd6);
          write_reg(REG_CHECK_INTERVAL, 16'd2);
          write_reg(REG_LOW_THRESHOLD, 16'd1023);
        end
        4, 5: begin
          write_reg(REG_DRIVE_LEN, 16'($urandom_range(0, 6)));
          write_reg(REG_CYCLE_LEN, 16'($urandom_range(0, 30)));
          write_reg(REG_LOW_THRESHOLD, 16'($urandom));
          write_reg(REG_CHECK_INTERVAL, 16'($urandom_range(0, 5)));
          write_reg(3'd5, 16'($urandom));
          write_reg(3'd6, 16'($urandom));
          write_reg(3'd7, 16'($urandom));
        end
        6: begin
          write_reg(REG_DRIVE_LEN, 16'd1);
          write_reg(REG_CYCLE_LEN, 16'hFFFF);
          write_reg(REG_CHECK_INTERVAL, 16'($urandom));
        end
        default: begin
          write_reg(REG_DRIVE_LEN, 16'hFFFF);
          write_reg(REG_CYCLE_LEN, 16'hFFFF);
          write_reg(REG_START_DELAY, 16'hFFFF);
          write_reg(REG_LOW_THRESHOLD, 16'($urandom));
          write_reg(REG_CHECK_INTERVAL, 16'h3FFF);
        end
      endcase

      // Mostly ticks with noise in the unused field, some conversions
      items_done = 0;
      while (items_done < RANDOM_ITEMS / NUM_PHASES) begin
        while (pending_items.size() >= FILL_LOW_MARK) @(posedge clk);
        if ($urandom_range(0, 99) < 5) begin
          // straddle the threshold half of the time
          if ($urandom_range(0, 1) == 1)
            adc = shadow_cfg.low_voltage_threshold + 10'($urandom_range(0, 2)) - 10'd1;
          else
            adc = 10'($urandom);
          pending_items.push_back(mk_item(1'b1, adc));
        end else begin
          pending_items.push_back(mk_item(1'b0, 10'($urandom)));
        end
        items_done++;
      end
    end

    // Drain what is still in flight, then let the pipeline settle
    drain = 0;
    while ((pending_items.size() != 0 || offer_busy || seq_outputs_q.size() != 0) &&
           drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (seq_outputs_q.size() != 0) begin
      $display("%0d result beats never arrived", seq_outputs_q.size());
      mismatches += seq_outputs_q.size();
    end

    if (mismatches == 0)
      $display("tb_biphasic_stim_pulse_sequencer_core: PASS");
    else
      $display("tb_biphasic_stim_pulse_sequencer_core: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bsps_pkg.sv
hdl/bsps_cfg_regs.sv
hdl/bsps_engine.sv
hdl/biphasic_stim_pulse_sequencer_core.sv
hdl/bsps_checker.sv
dv/tb_biphasic_stim_pulse_sequencer_core.sv
